FILE: rtl/modexp_pkg.sv
// shared constants, types and states for the modular exponentiation block
// depends on nothing

package modexp_pkg;

  localparam int unsigned W        = 30;
  localparam int unsigned EXP_BITS = 31;
  localparam int unsigned BCNT_W   = $clog2(W);
  localparam int unsigned ECNT_W   = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

  localparam logic [W-1:0] MOD_P = W'(1000000007);

  typedef struct packed {
    logic clr;
    logic step;
  } lane_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } state_e;

  function automatic logic [W-1:0] reduce_once(input logic [W-1:0] v);
    logic [W-1:0] r;
    r = (v >= MOD_P) ? v - MOD_P : v;
    return r;
  endfunction

endpackage

FILE: rtl/modexp_mulser.sv
// bit-serial interleaved modular multiplier lane, multiplier bits fed msb first
// depends on modexp_pkg

module modexp_mulser
  import modexp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  lane_ctl_t    ctl_i,
  input  logic [W-1:0] mcand_i,
  input  logic         bit_i,
  output logic [W-1:0] prod_o
);

  localparam logic [W+1:0] P1 = {2'b00, MOD_P};
  localparam logic [W+1:0] P2 = {1'b0, MOD_P, 1'b0};

  logic [W-1:0] r_q, r_d;
  logic [W+1:0] t;

  always_comb begin
    t = {1'b0, r_q, 1'b0} + (bit_i ? {2'b00, mcand_i} : '0);
    r_d = r_q;
    if (ctl_i.clr) begin
      r_d = '0;
    end else if (ctl_i.step) begin
      priority if (t >= P2) begin
        r_d = W'(t - P2);
      end else if (t >= P1) begin
        r_d = W'(t - P1);
      end else begin
        r_d = W'(t);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
    end else begin
      r_q <= r_d;
    end
  end

  assign prod_o = r_q;

endmodule

FILE: rtl/modular_exponentiation_top.sv
// top level: square-and-multiply sequencer over two bit-serial multiplier lanes
// depends on modexp_pkg and modexp_mulser
//
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+--------------------------
//  input    | base_i[29:0], exponent_i[30:0]         | start & !busy
//  result   | power_o[29:0]                          | valid_o, one cycle
//
// one item is worked on at a time; a new one is not accepted while busy
// each exponent bit costs one serial multiply pass, both lanes in step
// busy is high from the accepting edge until the result strobe has gone
// reset clears the sequencer; the receiver cannot stall the result

module modular_exponentiation_top
  import modexp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [W-1:0]        base_i,
  input  logic [EXP_BITS-1:0] exponent_i,
  output logic                valid_o,
  output logic [W-1:0]        power_o
);

  state_e state_q, state_d;

  logic [W-1:0]        acc_q, acc_d;
  logic [W-1:0]        sq_q, sq_d;
  logic [W-1:0]        scan_q, scan_d;
  logic [EXP_BITS-1:0] exp_q, exp_d;
  logic [BCNT_W-1:0]   bcnt_q, bcnt_d;
  logic [ECNT_W-1:0]   ecnt_q, ecnt_d;

  lane_ctl_t    lane_ctl;
  logic [W-1:0] acc_prod, sq_prod;

  modexp_mulser u_acc_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (lane_ctl),
    .mcand_i (acc_q),
    .bit_i   (scan_q[W-1]),
    .prod_o  (acc_prod)
  );

  modexp_mulser u_sq_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (lane_ctl),
    .mcand_i (sq_q),
    .bit_i   (scan_q[W-1]),
    .prod_o  (sq_prod)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start) state_d = ST_MUL;
      ST_MUL:  if (bcnt_q == '0) state_d = ST_UPD;
      ST_UPD: begin
        if (ecnt_q == ECNT_W'(EXP_BITS - 1)) state_d = ST_DONE;
        else state_d = ST_MUL;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    acc_d    = acc_q;
    sq_d     = sq_q;
    scan_d   = scan_q;
    exp_d    = exp_q;
    bcnt_d   = bcnt_q;
    ecnt_d   = ecnt_q;
    lane_ctl = '0;
    unique case (state_q)
      ST_IDLE: begin
        lane_ctl.clr = 1'b1;
        if (start) begin
          acc_d  = W'(1);
          sq_d   = reduce_once(base_i);
          scan_d = reduce_once(base_i);
          exp_d  = exponent_i;
          bcnt_d = BCNT_W'(W - 1);
          ecnt_d = '0;
        end
      end
      ST_MUL: begin
        lane_ctl.step = 1'b1;
        scan_d = {scan_q[W-2:0], 1'b0};
        bcnt_d = bcnt_q - 1'b1;
      end
      ST_UPD: begin
        lane_ctl.clr = 1'b1;
        if (exp_q[0]) acc_d = acc_prod;
        sq_d   = sq_prod;
        scan_d = sq_prod;
        exp_d  = exp_q >> 1;
        bcnt_d = BCNT_W'(W - 1);
        ecnt_d = ecnt_q + 1'b1;
      end
      ST_DONE: begin
        lane_ctl.clr = 1'b1;
      end
      default: begin
        lane_ctl.clr = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bcnt_q  <= '0;
      ecnt_q  <= '0;
    end else begin
      state_q <= state_d;
      bcnt_q  <= bcnt_d;
      ecnt_q  <= ecnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    sq_q   <= sq_d;
    scan_q <= scan_d;
    exp_q  <= exp_d;
  end

  assign busy    = (state_q != ST_IDLE);
  assign valid_o = (state_q == ST_DONE);
  assign power_o = acc_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !valid_o)
    else $error("busy not raised after accepting an item");

  a_result_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> power_o < MOD_P)
    else $error("result not reduced below modulus");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o && !busy)
    else $error("result strobe longer than one cycle");

  a_lanes_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |-> acc_prod < MOD_P && sq_prod < MOD_P)
    else $error("multiplier lane left range");

endmodule
